FILE: rtl/swco_pkg.sv
// Shared types, codes and helpers for the shifter with carry-out.
// No dependencies; every other file in rtl/ uses this package.
`default_nettype none

package swco_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned RotWidth  = 5;

   // shift kinds as carried on req_op
   localparam logic [1:0] OP_LSL = 2'd0;
   localparam logic [1:0] OP_LSR = 2'd1;
   localparam logic [1:0] OP_ASR = 2'd2;
   localparam logic [1:0] OP_ROR = 2'd3;

   localparam logic [DataWidth-1:0] ALL_ONES = '1;

   // where the carry-out comes from
   typedef enum logic [1:0] {
      CY_CIN  = 2'd0,
      CY_BIT  = 2'd1,
      CY_ZERO = 2'd2
   } carry_sel_type;

   // decode stage -> coarse rotate stage
   typedef struct packed {
      logic                 valid;
      logic [DataWidth-1:0] operand;
      logic [RotWidth-1:0]  rot;
      logic                 mask_none;
      logic                 mask_left;
      logic [RotWidth-1:0]  mask_cnt;
      logic                 fill;
      carry_sel_type        cy_sel;
      logic [RotWidth-1:0]  cy_idx;
      logic                 carry_in;
   } dec_type;

   // coarse rotate stage -> fine rotate / merge stage
   typedef struct packed {
      logic                 valid;
      logic [DataWidth-1:0] data;
      logic [1:0]           rot_fine;
      logic [DataWidth-1:0] mask;
      logic                 fill;
      logic                 carry;
   } mid_type;

   function automatic logic [DataWidth-1:0] rotr32(input logic [DataWidth-1:0] x,
                                                    input logic [RotWidth-1:0]  s);
      logic [2*DataWidth-1:0] w;
      w = {x, x} >> s;
      return w[DataWidth-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/swco_decode.sv
// First stage: folds every shift kind and special amount into one
// rotate / mask / fill / carry-select recipe. Depends on swco_pkg.
`default_nettype none

module swco_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [1:0]        req_op,
   input  wire logic [31:0]       req_operand,
   input  wire logic [7:0]        req_amount,
   input  wire logic              req_from_immediate,
   input  wire logic              req_carry_in,
   output swco_pkg::dec_type      dec_ff
);

   swco_pkg::dec_type dec_in;

   logic       amt_zero;
   logic [7:0] amt;
   logic       big;
   logic       eq32;
   logic [4:0] n5;

   assign amt_zero = (req_amount == 8'd0);
   // immediate zero on LSR/ASR means 32
   assign amt      = amt_zero ? 8'd32 : req_amount;
   assign big      = (amt[7:5] != 3'd0);
   assign eq32     = (amt == 8'd32);
   assign n5       = amt[4:0];

   always_comb begin
      dec_in           = '0;
      dec_in.valid     = start;
      dec_in.operand   = req_operand;
      dec_in.carry_in  = req_carry_in;
      dec_in.cy_sel    = swco_pkg::CY_CIN;
      if (amt_zero && (!req_from_immediate || req_op == swco_pkg::OP_LSL)) begin
         // pass through: rotate 0, full mask, carry kept
         dec_in.cy_sel = swco_pkg::CY_CIN;
      end else if (amt_zero && req_op == swco_pkg::OP_ROR) begin
         // RRX: rotate by one, carry_in fills bit 31
         dec_in.rot      = 5'd1;
         dec_in.mask_cnt = 5'd1;
         dec_in.fill     = req_carry_in;
         dec_in.cy_sel   = swco_pkg::CY_BIT;
         dec_in.cy_idx   = 5'd0;
      end else begin
         unique case (req_op)
            swco_pkg::OP_LSL: begin
               if (!big) begin
                  dec_in.rot       = 5'd0 - n5;
                  dec_in.mask_left = 1'b1;
                  dec_in.mask_cnt  = n5;
                  dec_in.cy_sel    = swco_pkg::CY_BIT;
                  dec_in.cy_idx    = 5'd0 - n5;
               end else begin
                  dec_in.mask_none = 1'b1;
                  dec_in.cy_sel    = eq32 ? swco_pkg::CY_BIT : swco_pkg::CY_ZERO;
                  dec_in.cy_idx    = 5'd0;
               end
            end
            swco_pkg::OP_LSR: begin
               if (!big) begin
                  dec_in.rot      = n5;
                  dec_in.mask_cnt = n5;
                  dec_in.cy_sel   = swco_pkg::CY_BIT;
                  dec_in.cy_idx   = n5 - 5'd1;
               end else begin
                  dec_in.mask_none = 1'b1;
                  dec_in.cy_sel    = eq32 ? swco_pkg::CY_BIT : swco_pkg::CY_ZERO;
                  dec_in.cy_idx    = 5'd31;
               end
            end
            swco_pkg::OP_ASR: begin
               dec_in.fill   = req_operand[31];
               dec_in.cy_sel = swco_pkg::CY_BIT;
               if (!big) begin
                  dec_in.rot      = n5;
                  dec_in.mask_cnt = n5;
                  dec_in.cy_idx   = n5 - 5'd1;
               end else begin
                  dec_in.mask_none = 1'b1;
                  dec_in.cy_idx    = 5'd31;
               end
            end
            swco_pkg::OP_ROR: begin
               // amount mod 32; a multiple of 32 wraps the carry index to bit 31
               dec_in.rot    = n5;
               dec_in.cy_sel = swco_pkg::CY_BIT;
               dec_in.cy_idx = n5 - 5'd1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff <= '0;
      end else begin
         dec_ff <= dec_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/swco_coarse.sv
// Second stage: rotate by multiples of four, build the keep mask and
// pick the carry-out bit. Depends on swco_pkg.
`default_nettype none

module swco_coarse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire swco_pkg::dec_type dec,
   output swco_pkg::mid_type      mid_ff
);

   swco_pkg::mid_type mid_in;

   always_comb begin
      mid_in          = '0;
      mid_in.valid    = dec.valid;
      mid_in.data     = swco_pkg::rotr32(dec.operand, {dec.rot[4:2], 2'b00});
      mid_in.rot_fine = dec.rot[1:0];
      mid_in.fill     = dec.fill;
      if (dec.mask_none) begin
         mid_in.mask = '0;
      end else if (dec.mask_left) begin
         mid_in.mask = swco_pkg::ALL_ONES << dec.mask_cnt;
      end else begin
         mid_in.mask = swco_pkg::ALL_ONES >> dec.mask_cnt;
      end
      case (dec.cy_sel)
         swco_pkg::CY_CIN:  mid_in.carry = dec.carry_in;
         swco_pkg::CY_BIT:  mid_in.carry = dec.operand[dec.cy_idx];
         swco_pkg::CY_ZERO: mid_in.carry = 1'b0;
         default:           mid_in.carry = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= '0;
      end else begin
         mid_ff <= mid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/swco_merge.sv
// Third stage: finish the rotate, merge kept bits with the fill bit and
// register the result beat. Depends on swco_pkg.
`default_nettype none

module swco_merge (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire swco_pkg::mid_type mid,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_shifted,
   output logic                   rsp_carry_out
);

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] shifted_ff;
   logic [31:0] shifted_in;
   logic        carry_ff;
   logic        carry_in;
   logic [31:0] rotated;

   assign rotated    = swco_pkg::rotr32(mid.data, {3'b000, mid.rot_fine});
   assign shifted_in = (rotated & mid.mask) | (~mid.mask & {32{mid.fill}});
   assign carry_in   = mid.carry;
   assign valid_in   = mid.valid;

   always_ff @(posedge clock) begin
      shifted_ff <= shifted_in;
      carry_ff   <= carry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_shifted   = shifted_ff;
   assign rsp_carry_out = carry_ff;

endmodule

`default_nettype wire

FILE: rtl/shifter_with_carry_out_top.sv
// Top level of the 32-bit shifter with carry-out: three register stages.
// Depends on swco_pkg, swco_decode, swco_coarse, swco_merge.
//
//   channel | ports                               | marked by
//   --------+-------------------------------------+------------------------
//   request | req_op req_operand req_amount       | start high, busy low
//           | req_from_immediate req_carry_in     |
//   result  | rsp_shifted rsp_carry_out           | rsp_valid, one cycle
//
// One beat in per cycle, one result per beat, registered in turn by the decode,
// coarse rotate and fine rotate/merge registers.
// busy is always low. Synchronous reset clears the stage valid bits;
// beats in flight at reset are dropped. The receiver cannot stall.
`default_nettype none

module shifter_with_carry_out_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_operand,
   input  wire logic [7:0]  req_amount,
   input  wire logic        req_from_immediate,
   input  wire logic        req_carry_in,
   output logic             rsp_valid,
   output logic [31:0]      rsp_shifted,
   output logic             rsp_carry_out
);

   swco_pkg::dec_type dec;
   swco_pkg::mid_type mid;

   assign busy = 1'b0;

   swco_decode u_decode (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_op             (req_op),
      .req_operand        (req_operand),
      .req_amount         (req_amount),
      .req_from_immediate (req_from_immediate),
      .req_carry_in       (req_carry_in),
      .dec_ff             (dec)
   );

   swco_coarse u_coarse (
      .clock  (clock),
      .reset  (reset),
      .dec    (dec),
      .mid_ff (mid)
   );

   swco_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .mid           (mid),
      .rsp_valid     (rsp_valid),
      .rsp_shifted   (rsp_shifted),
      .rsp_carry_out (rsp_carry_out)
   );

`ifndef NO_ASSERTIONS
   // every accepted beat comes out as a result beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##3 rsp_valid)
      else $error("result beat missing after accepted request");

   // no result beat without a matching earlier request
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !reset, 3))
      else $error("result beat without matching request");

   // register-form zero amount passes value and carry straight through
   a_zero_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_amount == 8'd0 && !req_from_immediate, 3)) |->
      (rsp_shifted == $past(req_operand, 3) && rsp_carry_out == $past(req_carry_in, 3)))
      else $error("zero-amount pass-through mismatch");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_shifter_with_carry_out_top.sv
// Self-checking testbench for shifter_with_carry_out_top: directed corner beats,
// then random beats, each checked against a behavioral barrel-shifter predictor.
// Depends on swco_pkg and the RTL under rtl/.
`default_nettype none

module tb_shifter_with_carry_out_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RandomBeats   = 1400;
   localparam int unsigned DrainCycles   = 8;
   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned IdlePercent   = 18;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] operand;
      logic [7:0]  amount;
      logic        from_immediate;
      logic        carry_in;
      logic        drain_first;   // hold this beat until all results are back
   } shift_beat_type;

   typedef struct packed {
      logic [31:0] shifted;
      logic        carry_out;
   } shift_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = swco_pkg::OP_LSL;
   logic [31:0] req_operand = '0;
   logic [7:0]  req_amount = '0;
   logic        req_from_immediate = 1'b0;
   logic        req_carry_in = 1'b0;
   logic        rsp_valid;
   logic [31:0] rsp_shifted;
   logic        rsp_carry_out;

   shift_beat_type   pending_beats[$];
   shift_result_type expected_results[$];
   shift_beat_type   beat_on_bus;
   int unsigned      accepted_count = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      stall_cycles = 0;
   logic             idle_now;

   shifter_with_carry_out_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_operand        (req_operand),
      .req_amount         (req_amount),
      .req_from_immediate (req_from_immediate),
      .req_carry_in       (req_carry_in),
      .rsp_valid          (rsp_valid),
      .rsp_shifted        (rsp_shifted),
      .rsp_carry_out      (rsp_carry_out)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic shift_result_type predict_shift(shift_beat_type b);
      shift_result_type r;
      int unsigned      n;
      logic [31:0]      v;
      logic             top;
      n   = b.amount;
      v   = b.operand;
      top = v[31];
      if (n == 0) begin
         if (!b.from_immediate || b.op == swco_pkg::OP_LSL) begin
            r.shifted   = v;
            r.carry_out = b.carry_in;
            return r;
         end
         if (b.op == swco_pkg::OP_ROR) begin
            // RRX
            r.shifted   = {b.carry_in, v[31:1]};
            r.carry_out = v[0];
            return r;
         end
         n = 32;   // immediate LSR/ASR #0 encode 32
      end
      case (b.op)
         swco_pkg::OP_LSL: begin
            if (n < 32) begin
               r.shifted   = v << n;
               r.carry_out = v[32-n];
            end else begin
               r.shifted   = '0;
               r.carry_out = (n == 32) ? v[0] : 1'b0;
            end
         end
         swco_pkg::OP_LSR: begin
            if (n < 32) begin
               r.shifted   = v >> n;
               r.carry_out = v[n-1];
            end else begin
               r.shifted   = '0;
               r.carry_out = (n == 32) ? top : 1'b0;
            end
         end
         swco_pkg::OP_ASR: begin
            if (n < 32) begin
               r.shifted   = $signed(v) >>> n;
               r.carry_out = v[n-1];
            end else begin
               r.shifted   = {32{top}};
               r.carry_out = top;
            end
         end
         default: begin
            n = n % 32;
            if (n == 0) begin
               r.shifted   = v;
               r.carry_out = top;
            end else begin
               r.shifted   = (v >> n) | (v << (32 - n));
               r.carry_out = v[n-1];
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic add_beat(input logic [1:0] op, input logic [31:0] operand,
                           input logic [7:0] amount, input logic imm,
                           input logic cin, input logic drain);
      shift_beat_type b;
      b.op             = op;
      b.operand        = operand;
      b.amount         = amount;
      b.from_immediate = imm;
      b.carry_in       = cin;
      b.drain_first    = drain;
      pending_beats.push_back(b);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(0, 31);
         3: return 32'h8000_0000 | $urandom;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] random_amount();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 8'd0;
      if (sel <= 6) return 8'($urandom_range(1, 31));
      if (sel == 7) return 8'($urandom_range(32, 33));
      return 8'($urandom_range(0, 255));
   endfunction

   // driver: one beat on the bus at a time, popped from pending_beats
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_results.push_back(predict_shift(beat_on_bus));
            accepted_count++;
         end
         if (!start || !busy) begin
            // no idling in one long stretch of the run
            idle_now = ($urandom_range(0, 99) < IdlePercent) &&
                       !(accepted_count >= 600 && accepted_count < 850);
            if (pending_beats.size() > 0 && !idle_now &&
                (!pending_beats[0].drain_first || expected_results.size() == 0)) begin
               beat_on_bus        = pending_beats.pop_front();
               start              <= 1'b1;
               req_op             <= beat_on_bus.op;
               req_operand        <= beat_on_bus.operand;
               req_amount         <= beat_on_bus.amount;
               req_from_immediate <= beat_on_bus.from_immediate;
               req_carry_in       <= beat_on_bus.carry_in;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result shifted=%h carry_out=%b",
                                      rsp_shifted, rsp_carry_out));
         end else begin
            shift_result_type e;
            e = expected_results.pop_front();
            if (rsp_shifted !== e.shifted)
               report_mismatch($sformatf("shifted got %h want %h",
                                         rsp_shifted, e.shifted));
            if (rsp_carry_out !== e.carry_out)
               report_mismatch($sformatf("carry_out got %b want %b",
                                         rsp_carry_out, e.carry_out));
         end
      end
   end

   // watchdog on cycles without any accepted beat or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("tb_shifter_with_carry_out_top: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      // zero amounts, register form: pass through
      add_beat(swco_pkg::OP_LSL, 32'h8000_0001, 8'd0, 1'b0, 1'b1, 1'b0);
      add_beat(swco_pkg::OP_LSR, 32'h8000_0001, 8'd0, 1'b0, 1'b0, 1'b0);
      add_beat(swco_pkg::OP_ASR, 32'hFFFF_0000, 8'd0, 1'b0, 1'b1, 1'b0);
      add_beat(swco_pkg::OP_ROR, 32'h0000_0001, 8'd0, 1'b0, 1'b1, 1'b0);
      // zero amounts, immediate form
      add_beat(swco_pkg::OP_LSL, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b1, 1'b0);
      add_beat(swco_pkg::OP_LSR, 32'h8000_0000, 8'd0, 1'b1, 1'b0, 1'b0);
      add_beat(swco_pkg::OP_ASR, 32'h8000_0000, 8'd0, 1'b1, 1'b0, 1'b0);
      add_beat(swco_pkg::OP_ASR, 32'h7FFF_FFFF, 8'd0, 1'b1, 1'b1, 1'b0);
      add_beat(swco_pkg::OP_ROR, 32'h0000_0001, 8'd0, 1'b1, 1'b1, 1'b0);
      add_beat(swco_pkg::OP_ROR, 32'hFFFF_FFFE, 8'd0, 1'b1, 1'b0, 1'b0);
      // 32 and beyond
      add_beat(swco_pkg::OP_LSL, 32'h0000_0001, 8'd32, 1'b0, 1'b0, 1'b0);
      add_beat(swco_pkg::OP_LSL, 32'hFFFF_FFFF, 8'd33, 1'b0, 1'b1, 1'b0);
      add_beat(swco_pkg::OP_LSR, 32'h8000_0000, 8'd32, 1'b0, 1'b0, 1'b0);
      add_beat(swco_pkg::OP_LSR, 32'hFFFF_FFFF, 8'd33, 1'b0, 1'b1, 1'b0);
      add_beat(swco_pkg::OP_ASR, 32'h8000_0000, 8'd32, 1'b0, 1'b0, 1'b0);
      add_beat(swco_pkg::OP_ASR, 32'h7FFF_FFFF, 8'd255, 1'b0, 1'b1, 1'b0);
      add_beat(swco_pkg::OP_ROR, 32'h8000_0000, 8'd32, 1'b0, 1'b0, 1'b0);
      add_beat(swco_pkg::OP_ROR, 32'h7FFF_FFFF, 8'd64, 1'b1, 1'b1, 1'b0);
      add_beat(swco_pkg::OP_ROR, 32'hFFFF_FFFF, 8'd255, 1'b1, 1'b0, 1'b0);
      add_beat(swco_pkg::OP_LSL, 32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1, 1'b0);
      // ordinary edges
      add_beat(swco_pkg::OP_ROR, 32'h0000_0001, 8'd1, 1'b0, 1'b0, 1'b0);
      add_beat(swco_pkg::OP_LSL, 32'h8000_0000, 8'd1, 1'b0, 1'b0, 1'b0);
      add_beat(swco_pkg::OP_LSL, 32'h0000_0003, 8'd31, 1'b1, 1'b0, 1'b0);
      add_beat(swco_pkg::OP_LSR, 32'h0000_0001, 8'd1, 1'b1, 1'b0, 1'b0);
      add_beat(swco_pkg::OP_ASR, 32'h8000_0000, 8'd31, 1'b1, 1'b1, 1'b0);

      for (int i = 0; i < RandomBeats; i++) begin
         add_beat(2'($urandom_range(0, 3)), random_operand(), random_amount(),
                  1'($urandom), 1'($urandom), (i % 300) == 0);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sample between edges so the driver and monitor have settled
      @(negedge clock);
      while (pending_beats.size() > 0 || start || expected_results.size() > 0)
         @(negedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_shifter_with_carry_out_top: clean");
      end else begin
         $display("tb_shifter_with_carry_out_top: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
